@@ src/gtg_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gtg_pkg
// Shared types and constants for the gap threshold grouping block.
// ----------------------------------------------------------------------------
package gtg_pkg;

    localparam int MAX_ITEMS     = 1024;
    localparam int POSITION_BITS = 32;
    localparam int IDX_W         = $clog2(MAX_ITEMS);
    localparam int CNT_W         = $clog2(MAX_ITEMS + 1);
    localparam int SUM_W         = CNT_W + 2;
    localparam int CMP_W         = (POSITION_BITS > 32) ? POSITION_BITS : 32;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_BUILD = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    localparam logic REG_MAX_GAP    = 1'b0;
    localparam logic REG_ITEM_COUNT = 1'b1;

    localparam logic KIND_BUILD = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_RUN,
        S_RD_ORD,
        S_RD_POS,
        S_MERGE,
        S_LB_ORD,
        S_LB_POS,
        S_LB_WR,
        S_Q_RD,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic [31:0]      max_gap;
        logic [CNT_W-1:0] count;   // clamped to 1 .. MAX_ITEMS
    } t_cfg;

    typedef struct packed {
        logic             kind;
        logic             same_group;
        logic             index_error;
        logic [10:0]      group_count;
    } t_result;

endpackage
`default_nettype wire

@@ src/gtg_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gtg_ram
// One write port, two registered read ports.
// ----------------------------------------------------------------------------
module gtg_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr_a,
    input  wire logic [AW-1:0]    i_raddr_b,
    output logic      [WIDTH-1:0] o_rdata_a,
    output logic      [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule
`default_nettype wire

@@ src/gtg_cfg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gtg_cfg
// APB register file: max_gap and item_count.
// ----------------------------------------------------------------------------
module gtg_cfg
    import gtg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    logic [31:0] r_max_gap;
    logic [10:0] r_item_count;
    logic        wr;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_gap    <= '0;
            r_item_count <= 11'd1;
        end else if (wr) begin
            unique case (paddr[2])
                REG_MAX_GAP:    r_max_gap    <= pwdata;
                REG_ITEM_COUNT: r_item_count <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_MAX_GAP:    prdata = r_max_gap;
            REG_ITEM_COUNT: prdata = {21'd0, r_item_count};
            default:        prdata = '0;
        endcase
    end

    // clamp count to 1 .. MAX_ITEMS
    always_comb begin
        o_cfg.max_gap = r_max_gap;
        priority if (r_item_count == 11'd0) begin
            o_cfg.count = CNT_W'(1);
        end else if (32'(r_item_count) > MAX_ITEMS) begin
            o_cfg.count = CNT_W'(MAX_ITEMS);
        end else begin
            o_cfg.count = CNT_W'(r_item_count);
        end
    end

endmodule
`default_nettype wire

@@ src/gtg_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gtg_ctrl
// Sequencer: loads, merge sort passes, labeling pass and queries, all
// through one compare unit and the position, order and label memories.
// ----------------------------------------------------------------------------
module gtg_ctrl
    import gtg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  t_cfg             i_cfg,
    input  wire logic        i_accept,
    input  wire logic [1:0]  i_mode,
    input  wire logic [9:0]  i_slot,
    input  wire logic [9:0]  i_other_slot,
    input  wire logic [31:0] i_position,
    input  wire logic        i_out_free,
    output logic             o_busy,
    output logic             o_res_valid,
    output t_result          o_res
);

    t_state r_state, n_state;

    logic [SUM_W-1:0] r_width, n_width;
    logic [SUM_W-1:0] r_lo, n_lo;
    logic [SUM_W-1:0] r_mid, n_mid;
    logic [SUM_W-1:0] r_hi, n_hi;
    logic [SUM_W-1:0] r_i, n_i;
    logic [SUM_W-1:0] r_j, n_j;
    logic [SUM_W-1:0] r_k, n_k;
    logic             r_src, n_src;
    logic [IDX_W-1:0] r_label, n_label;
    logic [POSITION_BITS-1:0] r_prev, n_prev;
    logic [CNT_W-1:0] r_groups, n_groups;
    logic [CNT_W-1:0] r_build_n, n_build_n;   // slots labeled by the last build
    logic             r_valid, n_valid;
    logic [9:0]       r_a, n_a;
    logic [9:0]       r_b, n_b;
    logic             r_kind, n_kind;

    // memory ports
    logic                     pos_we;
    logic [POSITION_BITS-1:0] pos_da, pos_db;
    logic                     ord_we_a, ord_we_b;
    logic [IDX_W-1:0]         ord_waddr, ord_wdata, ord_ra, ord_rb;
    logic [IDX_W-1:0]         oa_da, oa_db, ob_da, ob_db, src_da, src_db;
    logic                     lab_we;
    logic [IDX_W-1:0]         lab_wdata, lab_da, lab_db;
    logic [IDX_W-1:0]         lab_a, lab_b;

    logic [SUM_W-1:0]         n_ext, lo2, lo1, sum2w;
    logic                     take_j, brk, q_err;
    logic [POSITION_BITS-1:0] diff;
    logic [IDX_W-1:0]         lbl;

    assign n_ext = SUM_W'(i_cfg.count);

    gtg_ram #(.DEPTH(MAX_ITEMS), .WIDTH(POSITION_BITS)) u_pos (
        .i_clk    (i_clk),
        .i_we     (pos_we),
        .i_waddr  (IDX_W'(i_slot)),
        .i_wdata  (POSITION_BITS'(i_position)),
        .i_raddr_a(src_da),
        .i_raddr_b(src_db),
        .o_rdata_a(pos_da),
        .o_rdata_b(pos_db)
    );

    gtg_ram #(.DEPTH(MAX_ITEMS), .WIDTH(IDX_W)) u_ord_a (
        .i_clk    (i_clk),
        .i_we     (ord_we_a),
        .i_waddr  (ord_waddr),
        .i_wdata  (ord_wdata),
        .i_raddr_a(ord_ra),
        .i_raddr_b(ord_rb),
        .o_rdata_a(oa_da),
        .o_rdata_b(oa_db)
    );

    gtg_ram #(.DEPTH(MAX_ITEMS), .WIDTH(IDX_W)) u_ord_b (
        .i_clk    (i_clk),
        .i_we     (ord_we_b),
        .i_waddr  (ord_waddr),
        .i_wdata  (ord_wdata),
        .i_raddr_a(ord_ra),
        .i_raddr_b(ord_rb),
        .o_rdata_a(ob_da),
        .o_rdata_b(ob_db)
    );

    gtg_ram #(.DEPTH(MAX_ITEMS), .WIDTH(IDX_W)) u_lab (
        .i_clk    (i_clk),
        .i_we     (lab_we),
        .i_waddr  (src_da),
        .i_wdata  (lab_wdata),
        .i_raddr_a(IDX_W'(r_a)),
        .i_raddr_b(IDX_W'(r_b)),
        .o_rdata_a(lab_da),
        .o_rdata_b(lab_db)
    );

    assign src_da = r_src ? ob_da : oa_da;
    assign src_db = r_src ? ob_db : oa_db;
    assign pos_we = i_accept && (i_mode == MODE_LOAD) && (32'(i_slot) < MAX_ITEMS);

    // shared compare unit
    assign take_j = (r_i >= r_mid) || ((r_j < r_hi) && (pos_db < pos_da));
    assign diff   = pos_da - r_prev;
    assign brk    = (r_k != '0) && (CMP_W'(diff) > CMP_W'(i_cfg.max_gap));
    assign lbl    = r_label + IDX_W'(brk);
    assign q_err  = !r_valid || (11'(r_a) >= 11'(i_cfg.count))
                  || (11'(r_b) >= 11'(i_cfg.count));

    // the label memory is not cleared: slots past the last build's range read as group 0
    assign lab_a = (CNT_W'(r_a) < r_build_n) ? lab_da : '0;
    assign lab_b = (CNT_W'(r_b) < r_build_n) ? lab_db : '0;

    assign lo2   = r_lo + (r_width << 1);
    assign lo1   = r_lo + r_width;
    assign sum2w = r_width << 1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= 1'b0;
            r_groups  <= '0;
            r_build_n <= '0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_groups  <= n_groups;
            r_build_n <= n_build_n;
        end
    end

    always_ff @(posedge i_clk) begin
        r_width <= n_width;
        r_lo    <= n_lo;
        r_mid   <= n_mid;
        r_hi    <= n_hi;
        r_i     <= n_i;
        r_j     <= n_j;
        r_k     <= n_k;
        r_src   <= n_src;
        r_label <= n_label;
        r_prev  <= n_prev;
        r_a     <= n_a;
        r_b     <= n_b;
        r_kind  <= n_kind;
    end

    always_comb begin
        n_state   = r_state;
        n_width   = r_width;
        n_lo      = r_lo;
        n_mid     = r_mid;
        n_hi      = r_hi;
        n_i       = r_i;
        n_j       = r_j;
        n_k       = r_k;
        n_src     = r_src;
        n_label   = r_label;
        n_prev    = r_prev;
        n_groups  = r_groups;
        n_build_n = r_build_n;
        n_valid   = r_valid;
        n_a       = r_a;
        n_b       = r_b;
        n_kind    = r_kind;
        ord_we_a  = 1'b0;
        ord_we_b  = 1'b0;
        ord_waddr = r_k[IDX_W-1:0];
        ord_wdata = take_j ? src_db : src_da;
        ord_ra    = r_i[IDX_W-1:0];
        ord_rb    = r_j[IDX_W-1:0];
        lab_we    = 1'b0;
        lab_wdata = lbl;

        unique case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    n_a = i_slot;
                    n_b = i_other_slot;
                    n_k = '0;
                    priority if (i_mode == MODE_BUILD) begin
                        n_state = S_INIT;
                    end else if (i_mode == MODE_QUERY) begin
                        n_state = S_Q_RD;
                    end
                end
            end
            // identity order into buffer A
            S_INIT: begin
                ord_we_a  = 1'b1;
                ord_wdata = r_k[IDX_W-1:0];
                n_k       = r_k + 1'b1;
                n_src     = 1'b0;
                n_width   = SUM_W'(1);
                n_lo      = '0;
                if (r_k + 1'b1 == n_ext) begin
                    if (n_ext == SUM_W'(1)) begin
                        n_k     = '0;
                        n_label = '0;
                        n_state = S_LB_ORD;
                    end else begin
                        n_state = S_RUN;
                    end
                end
            end
            S_RUN: begin
                n_mid   = (lo1 < n_ext) ? lo1 : n_ext;
                n_hi    = (lo2 < n_ext) ? lo2 : n_ext;
                n_i     = r_lo;
                n_j     = (lo1 < n_ext) ? lo1 : n_ext;
                n_k     = r_lo;
                n_state = S_RD_ORD;
            end
            S_RD_ORD: n_state = S_RD_POS;
            S_RD_POS: n_state = S_MERGE;
            S_MERGE: begin
                ord_we_a = r_src;
                ord_we_b = !r_src;
                if (take_j) begin
                    n_j = r_j + 1'b1;
                end else begin
                    n_i = r_i + 1'b1;
                end
                n_k = r_k + 1'b1;
                if (r_k + 1'b1 == r_hi) begin
                    if (lo2 >= n_ext) begin
                        n_width = sum2w;
                        n_src   = !r_src;
                        n_lo    = '0;
                        if (sum2w >= n_ext) begin
                            n_k     = '0;
                            n_label = '0;
                            n_state = S_LB_ORD;
                        end else begin
                            n_state = S_RUN;
                        end
                    end else begin
                        n_lo    = lo2;
                        n_state = S_RUN;
                    end
                end else begin
                    n_state = S_RD_ORD;
                end
            end
            S_LB_ORD: begin
                ord_ra  = r_k[IDX_W-1:0];
                n_state = S_LB_POS;
            end
            S_LB_POS: begin
                ord_ra  = r_k[IDX_W-1:0];
                n_state = S_LB_WR;
            end
            S_LB_WR: begin
                ord_ra  = r_k[IDX_W-1:0];
                lab_we  = 1'b1;
                n_label = lbl;
                n_prev  = pos_da;
                n_k     = r_k + 1'b1;
                if (r_k + 1'b1 == n_ext) begin
                    n_groups  = CNT_W'(lbl) + 1'b1;
                    n_build_n = i_cfg.count;
                    n_valid   = 1'b1;
                    n_kind    = KIND_BUILD;
                    n_state   = S_RESULT;
                end else begin
                    n_state = S_LB_ORD;
                end
            end
            S_Q_RD: begin
                n_kind  = KIND_QUERY;
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_RESULT);

    always_comb begin
        o_res.kind        = r_kind;
        o_res.group_count = 11'(r_groups);
        if (r_kind == KIND_QUERY) begin
            o_res.index_error = q_err;
            o_res.same_group  = !q_err && (lab_a == lab_b);
        end else begin
            o_res.index_error = 1'b0;
            o_res.same_group  = 1'b0;
        end
    end

endmodule
`default_nettype wire

@@ src/gap_threshold_grouping.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gap_threshold_grouping
// 1-D single-linkage grouping of stored positions by a gap threshold.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall) carries one request: mode, slot,
// other_slot, position. Output channel (o_out_valid / i_out_stall) carries
// kind, same_group, index_error, group_count. max_gap and item_count sit on
// the APB port at byte addresses 0 and 4; write them only while idle.
//
// Load: written in the accept cycle, no result; the next request may follow
//   in the next cycle.
// Query: two label reads, then the result is registered in the output register.
// Build: order init, then ceil(log2 n) merge passes that read the order
//   and position memories and merge each element, then a labeling pass;
//   the single compare unit and the registered read of the position
//   memory set the pace of each step.
// o_in_stall is high while a build or query is in flight. A finished result
// waits in the output register; a stalled receiver holds it and the block
// still takes loads behind it. Reset clears the control state, the
// build-done flag, the group count and the labeled-slot count; memory
// contents are undefined until written, so there is no clearing pass.
// ----------------------------------------------------------------------------
module gap_threshold_grouping
    import gtg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_mode,
    input  wire logic [9:0]  i_slot,
    input  wire logic [9:0]  i_other_slot,
    input  wire logic [31:0] i_position,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_kind,
    output logic             o_same_group,
    output logic             o_index_error,
    output logic [10:0]      o_group_count,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    t_cfg    cfg;
    t_result res;
    t_result r_out;
    logic    r_out_valid;
    logic    busy, res_valid, out_free, accept;

    gtg_cfg u_cfg (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .o_cfg  (cfg)
    );

    // output slot frees when empty or taken this cycle
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = busy;
    assign accept     = i_in_valid && !busy;

    gtg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_accept    (accept),
        .i_mode      (i_mode),
        .i_slot      (i_slot),
        .i_other_slot(i_other_slot),
        .i_position  (i_position),
        .i_out_free  (out_free),
        .o_busy      (busy),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_out.kind;
    assign o_same_group  = r_out.same_group;
    assign o_index_error = r_out.index_error;
    assign o_group_count = r_out.group_count;

    a_build_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == KIND_BUILD) |-> !o_same_group && !o_index_error)
        else $error("build result carries query flags");

    a_err_not_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_index_error |-> !o_same_group)
        else $error("error answer claims same group");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_group_count) <= MAX_ITEMS))
        else $error("group count beyond capacity");

    a_result_needs_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> busy)
        else $error("result pending while idle");

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for gap_threshold_grouping: loads, builds and queries
// are driven against a behavioral grouping predictor under random idling.
// ----------------------------------------------------------------------------
module tb_top;
    import gtg_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_mode;
    logic [9:0]  i_slot;
    logic [9:0]  i_other_slot;
    logic [31:0] i_position;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_kind;
    logic        o_same_group;
    logic        o_index_error;
    logic [10:0] o_group_count;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    gap_threshold_grouping u_dut (.*);

    localparam logic [1:0] MODE_SPARE = 2'd3;   // no operation, no result

    // Predictor state
    logic [31:0] gap_limit;
    logic [10:0] count_reg;
    logic [31:0] positions [MAX_ITEMS];
    int          labels    [MAX_ITEMS];
    bit          built;
    logic [10:0] groups;

    t_result     pending_results [$];
    int          fail_count;
    int          cycle_count;
    int          rx_wait;     // receiver stall cycles left for this result
    bit          hold_off;    // long receiver stall requested
    bit          rx_random;   // receiver idles at random
    bit          tx_random;   // sender idles at random

    localparam int CYCLE_LIMIT = 4000000;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int clamped_count();
        int c;
        c = count_reg;
        if (c < 1) c = 1;
        if (c > MAX_ITEMS) c = MAX_ITEMS;
        return c;
    endfunction

    // Stable sort of slots by position, then split on gaps above the limit.
    function automatic void group_slots();
        int n, lbl, i, j, t;
        int order [MAX_ITEMS];
        n = clamped_count();
        for (i = 0; i < MAX_ITEMS; i++) labels[i] = 0;
        for (i = 0; i < n; i++) order[i] = i;
        // insertion sort keeps ties in slot order
        for (i = 1; i < n; i++) begin
            t = order[i];
            j = i - 1;
            while (j >= 0 && positions[order[j]] > positions[t]) begin
                order[j+1] = order[j];
                j--;
            end
            order[j+1] = t;
        end
        lbl = 0;
        for (i = 1; i < n; i++) begin
            if (positions[order[i]] - positions[order[i-1]] > gap_limit) lbl++;
            labels[order[i]] = lbl;
        end
        groups = 11'(lbl + 1);
        built  = 1'b1;
    endfunction

    function automatic void predict_request(logic [1:0] mode, logic [9:0] a,
                                            logic [9:0] b, logic [31:0] pos);
        t_result r;
        bit err;
        int n;
        r = '0;
        case (mode)
            MODE_LOAD: begin
                positions[a] = pos;
            end
            MODE_BUILD: begin
                group_slots();
                r.kind        = KIND_BUILD;
                r.group_count = groups;
                pending_results = {pending_results, r};
            end
            MODE_QUERY: begin
                n   = clamped_count();
                err = !built || a >= n || b >= n;
                r.kind        = KIND_QUERY;
                r.index_error = err;
                r.same_group  = !err && labels[a] == labels[b];
                r.group_count = groups;
                pending_results = {pending_results, r};
            end
            default: ;
        endcase
    endfunction

    // Send one request; sender gap drawn per request. Valid stays up after
    // the accept so back-to-back requests follow without a gap.
    task automatic send_request(logic [1:0] mode, logic [9:0] a, logic [9:0] b,
                                logic [31:0] pos);
        int gap;
        gap = tx_random ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_mode       <= mode;
        i_slot       <= a;
        i_other_slot <= b;
        i_position   <= pos;
        do @(posedge i_clk); while (o_in_stall);
        predict_request(mode, a, b, pos);
    endtask

    // One write; the caller ends the transfer.
    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    // Drop valid, wait for all results, then a few idle cycles.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_config(logic [31:0] gap, logic [10:0] cnt);
        drain();
        apb_write({REG_MAX_GAP, 2'b00}, gap);
        apb_write({REG_ITEM_COUNT, 2'b00}, {21'd0, cnt});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        gap_limit = gap;
        count_reg = cnt;
    endtask

    // Receiver: random wait drawn per result, or a long counted hold-off.
    always @(posedge i_clk) begin
        int draw;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            rx_wait     <= 0;
        end else if (hold_off) begin
            i_out_stall <= 1'b1;
        end else if (o_out_valid && !i_out_stall) begin
            draw = rx_random ? $urandom_range(0, 14) : 0;
            rx_wait     <= draw;
            i_out_stall <= (draw != 0);
        end else if (rx_wait > 0) begin
            rx_wait     <= rx_wait - 1;
            i_out_stall <= (rx_wait > 1);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with none expected");
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_kind !== want.kind) begin
                    $error("kind exp %0d got %0d", want.kind, o_kind);
                    fail_count++;
                end
                if (o_same_group !== want.same_group) begin
                    $error("same_group exp %0d got %0d", want.same_group, o_same_group);
                    fail_count++;
                end
                if (o_index_error !== want.index_error) begin
                    $error("index_error exp %0d got %0d", want.index_error,
                           o_index_error);
                    fail_count++;
                end
                if (o_group_count !== want.group_count) begin
                    $error("group_count exp %0d got %0d", want.group_count,
                           o_group_count);
                    fail_count++;
                end
            end
        end
    end

    // Load slots 0..n-1 with clustered random positions.
    task automatic load_slots(int n, logic [31:0] spread);
        logic [31:0] base;
        base = $urandom;
        for (int i = 0; i < n; i++)
            send_request(MODE_LOAD, 10'(i), 10'($urandom),
                         ($urandom_range(0, 3) == 0) ? $urandom
                                                      : base + $urandom_range(0, spread));
    endtask

    task automatic random_query(int n);
        int a, b;
        a = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, n - 1);
        b = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, n - 1);
        send_request(MODE_QUERY, 10'(a), 10'(b), $urandom);
    endtask

    // Directed: query before build, single item, ties, extremes, mode 3.
    task automatic test_directed();
        send_request(MODE_QUERY, 10'd0, 10'd0, 32'd0);          // no build yet
        send_request(MODE_LOAD, 10'd0, 10'h3FF, 32'hFFFF_FFFF);
        send_request(MODE_BUILD, 10'h3FF, 10'h3FF, 32'hFFFF_FFFF); // single item
        send_request(MODE_QUERY, 10'd0, 10'd0, 32'd0);
        send_request(MODE_QUERY, 10'd0, 10'd1, 32'd0);           // out of range
        send_request(MODE_SPARE, 10'h3FF, 10'h3FF, 32'hFFFF_FFFF); // unused mode
        set_config(32'd0, 11'd4);
        send_request(MODE_LOAD, 10'd1, 10'd0, 32'd0);
        send_request(MODE_LOAD, 10'd2, 10'd0, 32'd0);            // tie with slot 1
        send_request(MODE_LOAD, 10'd3, 10'd0, 32'h8000_0000);
        send_request(MODE_BUILD, 10'd0, 10'd0, 32'd0);
        send_request(MODE_QUERY, 10'd1, 10'd2, 32'd0);
        send_request(MODE_QUERY, 10'd0, 10'd3, 32'd0);
        send_request(MODE_QUERY, 10'd3, 10'h3FF, 32'd0);
        set_config(32'hFFFF_FFFF, 11'd4);                         // all linked
        send_request(MODE_BUILD, 10'd0, 10'd0, 32'd0);
        send_request(MODE_QUERY, 10'd0, 10'd1, 32'd0);
        set_config(32'd0, 11'd0);                                 // clamps to 1
        send_request(MODE_BUILD, 10'd0, 10'd0, 32'd0);
        send_request(MODE_QUERY, 10'd0, 10'd0, 32'd0);
        set_config(32'd0, 11'h7FF);                               // clamps to max
        send_request(MODE_QUERY, 10'h3FF, 10'd0, 32'd0);          // checked vs count
    endtask

    // One larger build with mixed spreads.
    task automatic test_large_build();
        set_config(32'd1 << $urandom_range(20, 31), 11'd80);
        load_slots(80, 32'hFFFF_FFFF);
        send_request(MODE_BUILD, 10'd0, 10'd0, 32'd0);
        repeat (10) random_query(80);
    endtask

    // Many small sessions: load, build, queries; random settings.
    task automatic test_random_sessions();
        int n;
        rx_random = 1'b1;
        tx_random = 1'b1;
        for (int s = 0; s < 25; s++) begin
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
            set_config($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 40), 11'(n));
            load_slots(n, 32'd100);
            if ($urandom_range(0, 5) == 0) random_query(n);
            send_request(MODE_BUILD, 10'($urandom), 10'($urandom), $urandom);
            repeat ($urandom_range(2, 6)) random_query(n);
            if ($urandom_range(0, 4) == 0) send_request(MODE_SPARE, 10'($urandom),
                                                         10'($urandom), $urandom);
            if (s % 10 == 9) begin
                rx_random = 1'b0;
                tx_random = 1'b0;
            end else begin
                rx_random = 1'b1;
                tx_random = 1'b1;
            end
        end
    endtask

    // Receiver holds off while requests keep coming; the block must stall.
    task automatic test_back_pressure();
        tx_random = 1'b0;
        set_config(32'd10, 11'd8);
        load_slots(8, 32'd50);
        send_request(MODE_BUILD, 10'd0, 10'd0, 32'd0);
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            begin
                repeat (6) random_query(8);
                i_in_valid <= 1'b0;
            end
        join
        tx_random = 1'b1;
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_mode       = MODE_LOAD;
        i_slot       = '0;
        i_other_slot = '0;
        i_position   = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        fail_count   = 0;
        cycle_count  = 0;
        hold_off     = 1'b0;
        rx_random    = 1'b0;
        tx_random    = 1'b0;
        gap_limit    = '0;
        count_reg    = 11'd1;
        built        = 1'b0;
        groups       = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_sessions();
        test_back_pressure();
        test_large_build();

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
